### hw/rtl/pcsd_pkg.sv
// Shared types and constants for the prefix code stream decoder.
`default_nettype none

package pcsd_pkg;

  localparam int SYMBOL_COUNT_DEF = 256;
  localparam int MAX_CODE_LEN_DEF = 32;
  localparam int ENTRY_LEN_W      = 6;
  localparam int ENTRY_CODE_W     = 32;
  localparam int BYTE_W           = 8;
  localparam int BYTE_TOP         = 7;

  localparam logic ACT_LOAD   = 1'b0;
  localparam logic ACT_STREAM = 1'b1;

  typedef struct packed {
    logic                    action;
    logic [7:0]              entry_symbol;
    logic [ENTRY_CODE_W-1:0] entry_code;
    logic [ENTRY_LEN_W-1:0]  entry_length;
    logic [BYTE_W-1:0]       stream_byte;
    logic                    stream_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_symbol;
    logic       out_error;
    logic       out_last;
  } out_item_t;

  typedef struct packed {
    logic [ENTRY_CODE_W-1:0] code;
    logic [ENTRY_LEN_W-1:0]  len;
  } tbl_entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FEED,
    ST_SCAN,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

### hw/rtl/prefix_code_stream_decoder.sv
// Prefix code stream decoder: table load, bit-serial accumulate, sequential table scan.
// Flow: a table load, or a byte with no held byte, is done without leaving idle. A held
//   byte is taken bit by bit: each bit is shifted in, then the table is scanned up to the
//   first match or the last entry. After the last bit, the last result is flushed.
// Requests: one at a time, busy high throughout; the scan makes one table read and one compare
//   per cycle. Results are registered; no stall. Sync reset empties the table.
`default_nettype none

module prefix_code_stream_decoder #(
  parameter int SYMBOL_COUNT = pcsd_pkg::SYMBOL_COUNT_DEF,
  parameter int MAX_CODE_LEN = pcsd_pkg::MAX_CODE_LEN_DEF
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  start,
  output logic                 busy,
  input  pcsd_pkg::in_item_t   in_item,
  output logic                 out_valid,
  output pcsd_pkg::out_item_t  out_item
);

  // Widths derived from the parameters.
  localparam int SYM_W      = (SYMBOL_COUNT > 2) ? $clog2(SYMBOL_COUNT) : 1;
  localparam int ACC_LEN_W  = $clog2(MAX_CODE_LEN + 1);
  localparam int CMP_LEN_W  = (ACC_LEN_W > pcsd_pkg::ENTRY_LEN_W) ? ACC_LEN_W
                                                                   : pcsd_pkg::ENTRY_LEN_W;
  localparam int CMP_W      = (MAX_CODE_LEN > pcsd_pkg::ENTRY_CODE_W) ? MAX_CODE_LEN
                                                                       : pcsd_pkg::ENTRY_CODE_W;
  localparam int BYTE_W     = pcsd_pkg::BYTE_W;
  localparam int BCNT_W     = $clog2(BYTE_W + 1);

  // ---------------------------------------------------------------------------
  // Code table: one write port (load request), one registered read port (scan).
  // Valid bits make never-written entries read as "no code".
  // ---------------------------------------------------------------------------
  pcsd_pkg::tbl_entry_t      tbl_mem [SYMBOL_COUNT];
  logic [SYMBOL_COUNT-1:0]   tbl_vld_r;
  pcsd_pkg::tbl_entry_t      rd_ent_r;
  logic                      rd_vld_r;
  logic [SYM_W-1:0]          rd_addr;
  logic                      tbl_we;
  logic [SYM_W-1:0]          wr_addr;

  // Sequencer and datapath registers.
  pcsd_pkg::state_t          state_r, state_nxt;
  logic [BYTE_W-1:0]         held_byte_r, held_byte_nxt;
  logic                      held_valid_r, held_valid_nxt;
  logic [MAX_CODE_LEN-1:0]   acc_r, acc_nxt;
  logic [ACC_LEN_W-1:0]      acc_len_r, acc_len_nxt;
  logic [BYTE_W-1:0]         work_byte_r, work_byte_nxt;
  logic [BCNT_W-1:0]         bit_cnt_r, bit_cnt_nxt;
  logic                      trailer_r, trailer_nxt;
  logic [SYM_W-1:0]          scan_addr_r, scan_addr_nxt;

  // One result is held back so the last one of an item can carry out_last.
  logic                      pend_valid_r, pend_valid_nxt;
  logic [7:0]                pend_sym_r, pend_sym_nxt;
  logic                      pend_err_r, pend_err_nxt;

  logic                      out_valid_r, out_valid_nxt;
  pcsd_pkg::out_item_t       out_item_r, out_item_nxt;

  // Request decode.
  logic                      accept;
  logic                      is_load;
  logic                      sym_in_range;
  logic [BCNT_W-1:0]         trail_cnt;
  logic [2:0]                trail_shift;

  // Compare unit: one table entry against the accumulator per cycle.
  logic [CMP_W-1:0]          cmp_mask;
  logic [CMP_W-1:0]          cmp_code;
  logic [CMP_W-1:0]          cmp_acc;
  logic                      hit;
  logic                      last_addr;
  logic                      overlong;
  logic                      bit_done;

  assign accept  = start && (state_r == pcsd_pkg::ST_IDLE);
  assign is_load = (in_item.action == pcsd_pkg::ACT_LOAD);

  assign sym_in_range = ({1'b0, in_item.entry_symbol} < 9'(SYMBOL_COUNT));
  assign tbl_we       = accept && is_load && sym_in_range;
  assign wr_addr      = in_item.entry_symbol[SYM_W-1:0];

  // Trailer occupancy: zero or anything above a full byte means a full byte.
  always_comb begin
    if ((in_item.stream_byte == '0) || (in_item.stream_byte > 8'(BYTE_W))) begin
      trail_cnt = BCNT_W'(BYTE_W);
    end else begin
      trail_cnt = BCNT_W'(in_item.stream_byte);
    end
    trail_shift = 3'(BCNT_W'(BYTE_W) - trail_cnt);
  end

  // Issue entry 0 while shifting, then walk the table one entry per cycle.
  assign rd_addr = (state_r == pcsd_pkg::ST_SCAN) ? (scan_addr_r + SYM_W'(1)) : '0;

  always_ff @(posedge clk) begin
    if (tbl_we) begin
      tbl_mem[wr_addr] <= '{code: in_item.entry_code, len: in_item.entry_length};
    end
    rd_ent_r <= tbl_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tbl_vld_r <= '0;
      rd_vld_r  <= 1'b0;
    end else begin
      if (tbl_we) begin
        tbl_vld_r[wr_addr] <= 1'b1;
      end
      rd_vld_r <= tbl_vld_r[rd_addr];
    end
  end

  // Match: same length and the low len code bits equal the accumulator.
  assign cmp_mask  = (CMP_W'(1) << rd_ent_r.len) - CMP_W'(1);
  assign cmp_code  = CMP_W'(rd_ent_r.code) & cmp_mask;
  assign cmp_acc   = CMP_W'(acc_r);
  assign hit       = rd_vld_r && (rd_ent_r.len != '0) &&
                     (CMP_LEN_W'(rd_ent_r.len) == CMP_LEN_W'(acc_len_r)) &&
                     (cmp_code == cmp_acc);
  assign last_addr = (scan_addr_r == SYM_W'(SYMBOL_COUNT - 1));
  assign overlong  = (acc_len_r >= ACC_LEN_W'(MAX_CODE_LEN));
  assign bit_done  = hit || last_addr;

  // ---------------------------------------------------------------------------
  // Next state.
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pcsd_pkg::ST_IDLE: begin
        if (accept && !is_load && held_valid_r) begin
          state_nxt = pcsd_pkg::ST_FEED;
        end
      end
      pcsd_pkg::ST_FEED: begin
        state_nxt = pcsd_pkg::ST_SCAN;
      end
      pcsd_pkg::ST_SCAN: begin
        if (bit_done) begin
          state_nxt = (bit_cnt_r == '0) ? pcsd_pkg::ST_DONE : pcsd_pkg::ST_FEED;
        end
      end
      pcsd_pkg::ST_DONE: begin
        state_nxt = pcsd_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = pcsd_pkg::ST_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Datapath and result outputs.
  // ---------------------------------------------------------------------------
  always_comb begin
    held_byte_nxt  = held_byte_r;
    held_valid_nxt = held_valid_r;
    acc_nxt        = acc_r;
    acc_len_nxt    = acc_len_r;
    work_byte_nxt  = work_byte_r;
    bit_cnt_nxt    = bit_cnt_r;
    trailer_nxt    = trailer_r;
    scan_addr_nxt  = scan_addr_r;
    pend_valid_nxt = pend_valid_r;
    pend_sym_nxt   = pend_sym_r;
    pend_err_nxt   = pend_err_r;
    out_valid_nxt  = 1'b0;
    out_item_nxt   = out_item_r;

    unique case (state_r)
      pcsd_pkg::ST_IDLE: begin
        if (accept && !is_load) begin
          if (!in_item.stream_end) begin
            // Data byte: release the held one, hold this one back.
            work_byte_nxt  = held_byte_r;
            bit_cnt_nxt    = BCNT_W'(BYTE_W);
            trailer_nxt    = 1'b0;
            held_byte_nxt  = in_item.stream_byte;
            held_valid_nxt = 1'b1;
          end else begin
            // Trailer: only the low bits of the held byte are data.
            work_byte_nxt  = held_byte_r << trail_shift;
            bit_cnt_nxt    = trail_cnt;
            trailer_nxt    = 1'b1;
            held_byte_nxt  = '0;
            held_valid_nxt = 1'b0;
            if (!held_valid_r) begin
              acc_nxt     = '0;
              acc_len_nxt = '0;
            end
          end
        end
      end
      pcsd_pkg::ST_FEED: begin
        // Shift the next stream bit in, MSB first, and restart the scan.
        acc_nxt       = {acc_r[MAX_CODE_LEN-2:0], work_byte_r[pcsd_pkg::BYTE_TOP]};
        acc_len_nxt   = acc_len_r + ACC_LEN_W'(1);
        work_byte_nxt = work_byte_r << 1;
        bit_cnt_nxt   = bit_cnt_r - BCNT_W'(1);
        scan_addr_nxt = '0;
      end
      pcsd_pkg::ST_SCAN: begin
        if (hit || (last_addr && overlong)) begin
          // New result: flush the pending one as a non-last result.
          out_valid_nxt           = pend_valid_r;
          out_item_nxt.out_symbol = pend_sym_r;
          out_item_nxt.out_error  = pend_err_r;
          out_item_nxt.out_last   = 1'b0;
          pend_valid_nxt          = 1'b1;
          pend_sym_nxt            = hit ? 8'(scan_addr_r) : 8'd0;
          pend_err_nxt            = !hit;
          acc_nxt                 = '0;
          acc_len_nxt             = '0;
        end
        if (!bit_done) begin
          scan_addr_nxt = scan_addr_r + SYM_W'(1);
        end
      end
      pcsd_pkg::ST_DONE: begin
        out_valid_nxt           = pend_valid_r;
        out_item_nxt.out_symbol = pend_sym_r;
        out_item_nxt.out_error  = pend_err_r;
        out_item_nxt.out_last   = 1'b1;
        pend_valid_nxt          = 1'b0;
        if (trailer_r) begin
          // End of stream: drop partial code, next byte starts fresh.
          acc_nxt     = '0;
          acc_len_nxt = '0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= pcsd_pkg::ST_IDLE;
      held_valid_r <= 1'b0;
      held_byte_r  <= '0;
      acc_r        <= '0;
      acc_len_r    <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      held_valid_r <= held_valid_nxt;
      held_byte_r  <= held_byte_nxt;
      acc_r        <= acc_nxt;
      acc_len_r    <= acc_len_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    work_byte_r <= work_byte_nxt;
    bit_cnt_r   <= bit_cnt_nxt;
    trailer_r   <= trailer_nxt;
    scan_addr_r <= scan_addr_nxt;
    pend_sym_r  <= pend_sym_nxt;
    pend_err_r  <= pend_err_nxt;
    out_item_r  <= out_item_nxt;
  end

  assign busy      = (state_r != pcsd_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  a_last_flush: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == pcsd_pkg::ST_DONE && pend_valid_r) |=> (out_valid && out_item.out_last))
    else $error("pending result not flushed as last");

  a_nonlast_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_item.out_last) |-> busy)
    else $error("non-last result after item finished");

  a_acc_bound: assert property (@(posedge clk) disable iff (!rst_n)
    acc_len_r <= ACC_LEN_W'(MAX_CODE_LEN))
    else $error("accumulator length beyond maximum code length");

  a_err_sym: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.out_error) |-> (out_item.out_symbol == 8'd0))
    else $error("error result carries a symbol");

endmodule

`default_nettype wire

### bench/tb_top.sv
// Self-checking testbench for the prefix code stream decoder.
`timescale 1ns / 1ps

module tb_top;
  import pcsd_pkg::*;

  // Worst item: 8 bits, each a shift plus a full table scan, plus closing cycles.
  localparam int ITEM_CYCLES_MAX = 8 * (SYMBOL_COUNT_DEF + 1) + 2;
  localparam int SETTLE_CYCLES   = ITEM_CYCLES_MAX + 50;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  in_item_t  in_item = '0;
  logic      out_valid;
  out_item_t out_item;

  prefix_code_stream_decoder dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Decoder model: code table, held-back byte and bit accumulator, all zero at the start,
  // as the block's own state is after reset.
  // ---------------------------------------------------------------------------
  bit [ENTRY_CODE_W-1:0] code_table [SYMBOL_COUNT_DEF];
  bit [ENTRY_LEN_W-1:0]  len_table  [SYMBOL_COUNT_DEF];
  bit [BYTE_W-1:0]       held_byte;
  bit                    held_ok;
  bit [63:0]             acc_bits;
  int                    acc_len;

  out_item_t burst_q[$];     // symbols decoded by the request being modeled
  out_item_t symbols_due[$]; // decoded symbols still to come out of the block
  int        fail_count;

  // Shift one stream bit into the accumulator and match it against the table.
  function void shift_stream_bit(input bit b);
    out_item_t sym;
    bit [63:0] mask;
    acc_bits = {acc_bits[62:0], b};
    acc_len++;
    for (int s = 0; s < SYMBOL_COUNT_DEF; s++) begin
      if (len_table[s] == 0 || int'(len_table[s]) != acc_len) continue;
      mask = (64'd1 << len_table[s]) - 64'd1;
      // Lowest index wins: stop at the first hit.
      if ((64'(code_table[s]) & mask) == (acc_bits & mask)) begin
        sym.out_symbol = 8'(s);
        sym.out_error  = 1'b0;
        sym.out_last   = 1'b0;
        burst_q.push_back(sym);
        acc_bits = '0;
        acc_len  = 0;
        return;
      end
    end
    // Overlong accumulation: flag it and start over.
    if (acc_len >= MAX_CODE_LEN_DEF) begin
      sym.out_symbol = '0;
      sym.out_error  = 1'b1;
      sym.out_last   = 1'b0;
      burst_q.push_back(sym);
      acc_bits = '0;
      acc_len  = 0;
    end
  endfunction

  // Apply one accepted request to the model and queue the symbols it decodes.
  function void decode_request(input in_item_t req);
    int        bit_count;
    out_item_t tail;
    burst_q.delete();
    if (req.action == ACT_LOAD) begin
      if (int'(req.entry_symbol) < SYMBOL_COUNT_DEF) begin
        code_table[req.entry_symbol] = req.entry_code;
        len_table[req.entry_symbol]  = req.entry_length;
      end
      return;
    end
    if (!req.stream_end) begin
      // Release the held byte in full, then hold the new one back.
      if (held_ok)
        for (int k = BYTE_TOP; k >= 0; k--) shift_stream_bit(held_byte[k]);
      held_byte = req.stream_byte;
      held_ok   = 1'b1;
    end else begin
      // Trailer: count of valid low bits, 0 and anything above a byte mean all.
      bit_count = int'(req.stream_byte);
      if (bit_count == 0 || bit_count > BYTE_W) bit_count = BYTE_W;
      if (held_ok)
        for (int k = bit_count - 1; k >= 0; k--) shift_stream_bit(held_byte[k]);
      held_ok   = 1'b0;
      held_byte = '0;
      acc_bits  = '0;
      acc_len   = 0;
    end
    if (burst_q.size() > 0) begin
      tail = burst_q.pop_back();
      tail.out_last = 1'b1;
      burst_q.push_back(tail);
    end
    foreach (burst_q[i]) symbols_due.push_back(burst_q[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // Result checker: the strobe is sampled at the edge that accepts the result,
  // so the values seen here are those from the cycle before the edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid === 1'b1) begin
      if (symbols_due.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("%0t: unexpected result sym=%0d err=%0b last=%0b", $realtime,
                   out_item.out_symbol, out_item.out_error, out_item.out_last);
      end else begin
        want = symbols_due.pop_front();
        if (out_item.out_symbol !== want.out_symbol || out_item.out_error !== want.out_error
            || out_item.out_last !== want.out_last) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: mismatch sym=%0d/%0d err=%0b/%0b last=%0b/%0b (expected/actual)",
                     $realtime, want.out_symbol, out_item.out_symbol, want.out_error,
                     out_item.out_error, want.out_last, out_item.out_last);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Request sender. Start stays high across back-to-back requests; otherwise it
  // drops right at the accepting edge so that the same request is never taken
  // twice.
  // ---------------------------------------------------------------------------
  bit hold_start;
  int next_gap;
  int sender_idle_pct;
  int requests_sent;

  function int pick_gap();
    if ($urandom_range(99) >= sender_idle_pct) return 0;
    // Mostly short gaps, sometimes long enough to land anywhere in a byte's scan.
    if ($urandom_range(3) == 0) return $urandom_range(1, ITEM_CYCLES_MAX + 100);
    return $urandom_range(1, 4);
  endfunction

  task automatic send_request(input in_item_t req);
    if (!hold_start) begin
      repeat (next_gap) @(posedge clk);
      start <= 1'b1;
    end
    in_item <= req;
    do @(posedge clk); while (busy !== 1'b0);
    decode_request(req);
    requests_sent++;
    next_gap   = pick_gap();
    hold_start = (next_gap == 0);
    if (!hold_start) start <= 1'b0;
  endtask

  // Drop start and wait until the block is idle with nothing outstanding.
  task automatic drain_decoder();
    if (hold_start) start <= 1'b0;
    hold_start = 1'b0;
    next_gap   = 0;
    do @(posedge clk); while (symbols_due.size() != 0 || busy !== 1'b0);
  endtask

  // Fill every field at random, so unused fields toggle too.
  function in_item_t random_request();
    in_item_t r;
    r.action       = 1'($urandom);
    r.entry_symbol = 8'($urandom);
    r.entry_code   = $urandom;
    r.entry_length = 6'($urandom);
    r.stream_byte  = 8'($urandom);
    r.stream_end   = 1'($urandom);
    return r;
  endfunction

  function in_item_t load_request(input bit [7:0] sym, input bit [31:0] code,
                                  input bit [5:0] len);
    in_item_t r;
    r = random_request();
    r.action       = ACT_LOAD;
    r.entry_symbol = sym;
    r.entry_code   = code;
    r.entry_length = len;
    return r;
  endfunction

  function in_item_t byte_request(input bit [7:0] b, input bit is_trailer);
    in_item_t r;
    r = random_request();
    r.action      = ACT_STREAM;
    r.stream_byte = b;
    r.stream_end  = is_trailer;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Directed tests
  // ---------------------------------------------------------------------------

  // Trailer with nothing held: no symbol must come out.
  task automatic test_empty_trailer();
    send_request(byte_request(8'd5, 1'b1));
  endtask

  // Table rules: ignored high code bits, duplicate codes, a full-length code,
  // a length that can never match, and a code removed in the middle of a stream.
  task automatic test_table_rules();
    send_request(load_request(8'd0, 32'hFFFF_FFFE, 6'd1));    // "0", junk above
    send_request(load_request(8'd200, 32'h0000_0002, 6'd2));  // "10"
    send_request(load_request(8'd255, 32'h0000_0006, 6'd3));  // "110"
    send_request(load_request(8'd7, 32'h0000_0002, 6'd2));    // "10" again, wins
    send_request(load_request(8'd128, 32'hFFFF_FFFF, 6'd32)); // 32 ones
    send_request(load_request(8'd1, 32'h0000_0000, 6'd63));   // never matches
    send_request(byte_request(8'h00, 1'b0));
    send_request(byte_request(8'hFF, 1'b0));                  // eight zero codes
    send_request(byte_request(8'hFF, 1'b0));
    send_request(byte_request(8'hFF, 1'b0));
    send_request(byte_request(8'hFF, 1'b0));
    send_request(byte_request(8'h6C, 1'b0));                  // full-length code
    send_request(load_request(8'd7, 32'h0000_0002, 6'd0));    // remove, byte held
    send_request(byte_request(8'h00, 1'b1));                  // trailer 0 means 8
  endtask

  // An unknown prefix runs past the longest code and must flag an error.
  task automatic test_overlong_error();
    send_request(byte_request(8'hE0, 1'b0));
    send_request(byte_request(8'h00, 1'b0));
    send_request(byte_request(8'h00, 1'b0));
    send_request(byte_request(8'h00, 1'b0));
    send_request(byte_request(8'hA5, 1'b0));
    send_request(byte_request(8'h03, 1'b1));                  // last byte cut short
  endtask

  // Trailer counts above a byte saturate.
  task automatic test_trailer_counts();
    send_request(byte_request(8'h12, 1'b0));
    send_request(byte_request(8'hFF, 1'b1));
  endtask

  // ---------------------------------------------------------------------------
  // Random streams: mostly a fresh prefix code followed by a few well-formed
  // streams, with some noise requests and streams left open.
  // ---------------------------------------------------------------------------
  bit [7:0] coded_syms[$];

  task automatic load_random_code();
    bit [31:0] leaf_code[$];
    int        leaf_len[$];
    bit        chosen[SYMBOL_COUNT_DEF];
    bit [7:0]  new_syms[$];
    bit [7:0]  sym;
    int        n_leaves;
    int        depth_cap;
    int        pick;
    int        guard;
    n_leaves  = $urandom_range(2, 10);
    depth_cap = $urandom_range(3, 12);
    leaf_code.push_back(32'd0);
    leaf_len.push_back(0);
    guard = 0;
    // Split random leaves of a code tree: the leaves form a complete prefix code.
    while (leaf_code.size() < n_leaves && guard < 200) begin
      pick = $urandom_range(leaf_code.size() - 1);
      if (leaf_len[pick] < depth_cap) begin
        leaf_code.push_back({leaf_code[pick][30:0], 1'b1});
        leaf_len.push_back(leaf_len[pick] + 1);
        leaf_code[pick] = {leaf_code[pick][30:0], 1'b0};
        leaf_len[pick]  = leaf_len[pick] + 1;
      end
      guard++;
    end
    // Sometimes leave a hole in the code so that overlong prefixes occur.
    if (leaf_code.size() > 2 && $urandom_range(3) == 0) begin
      pick = $urandom_range(leaf_code.size() - 1);
      leaf_code.delete(pick);
      leaf_len.delete(pick);
    end
    foreach (chosen[i]) chosen[i] = 1'b0;
    foreach (leaf_code[i]) begin
      do sym = 8'($urandom); while (chosen[sym]);
      chosen[sym] = 1'b1;
      new_syms.push_back(sym);
    end
    // Remove codes of the previous table that are not reused.
    foreach (coded_syms[i])
      if (!chosen[coded_syms[i]]) send_request(load_request(coded_syms[i], $urandom, 6'd0));
    // Load the new codes with random junk above each length.
    foreach (leaf_code[i])
      send_request(load_request(new_syms[i], ($urandom << leaf_len[i]) | leaf_code[i],
                                6'(leaf_len[i])));
    coded_syms = new_syms;
  endtask

  task automatic test_random_streams(input int idle_pct, input int n_requests);
    int target;
    int n_streams;
    int n_bytes;
    bit [7:0] count;
    sender_idle_pct = idle_pct;
    target = requests_sent + n_requests;
    while (requests_sent < target) begin
      if ($urandom_range(99) < 12) begin
        send_request(random_request());
      end else begin
        load_random_code();
        n_streams = $urandom_range(1, 3);
        for (int t = 0; t < n_streams; t++) begin
          n_bytes = $urandom_range(1, 10);
          for (int b = 0; b < n_bytes; b++) send_request(byte_request(8'($urandom), 1'b0));
          // Leave some streams open so the next requests land mid stream.
          if ($urandom_range(9) != 0) begin
            count = ($urandom_range(4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 8));
            send_request(byte_request(count, 1'b1));
          end
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    fail_count      = 0;
    hold_start      = 1'b0;
    next_gap        = 0;
    sender_idle_pct = 0;
    requests_sent   = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    test_empty_trailer();
    test_table_rules();
    test_overlong_error();
    test_trailer_counts();
    drain_decoder();

    test_random_streams(30, 80);
    drain_decoder();
    test_random_streams(58, 80);
    drain_decoder();
    test_random_streams(0, 75);
    drain_decoder();

    // Hold for a full item time to catch stray results.
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (symbols_due.size() != 0) begin
      fail_count += symbols_due.size();
      $display("%0d decoded symbols never came out", symbols_due.size());
    end
    if (fail_count == 0) begin
      $display("prefix_code_stream_decoder regression: pass");
    end else begin
      $display("prefix_code_stream_decoder regression: fail");
    end
    $finish;
  end

  // Watchdog: the slowest correct run stays well under a third of this.
  initial begin
    #(64'd50_000_000);
    $display("prefix_code_stream_decoder regression: fail");
    $finish;
  end

endmodule

### filelist.f
hw/rtl/pcsd_pkg.sv
hw/rtl/prefix_code_stream_decoder.sv
bench/tb_top.sv
